### rtl/lsl_pkg.sv
// ----------------------------------------------------------------------------
// lsl_pkg: shared types, constants and helpers of the stereo peak limiter
// fixed formats, sequencer states, tap weights, rounding and clamping
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lsl_pkg;

  localparam int SAMPLE_W      = 24;
  localparam int GAIN_W        = 24;
  localparam int MUL_W         = 26;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int WEIGHT_W      = 21;
  localparam int ACC_W         = 50;
  localparam int PRED_W        = 25;
  localparam int QUOT_W        = 24;
  localparam int NUM_W         = 48;
  localparam int DELAY_DEPTH   = 64;
  localparam int HISTORY_DEPTH = 16;
  localparam int HIST_W        = 4;
  localparam int RAMP_LENGTH   = 4;

  localparam logic [GAIN_W-1:0] UNITY_GAIN  = 24'd8388608;
  localparam logic [23:0]       COEF_RISE   = 24'd16730677;
  localparam logic [23:0]       COEF_FALL   = 24'd16773721;
  localparam logic [23:0]       COEF_SECOND = 24'd16637987;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_L,
    S_MUL_R,
    S_RAMP,
    S_GAIN,
    S_SCAN,
    S_ENV1,
    S_ENV1W,
    S_ENV2W,
    S_SUM,
    S_PRED,
    S_DIV,
    S_FIN,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [PRED_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [WEIGHT_W-1:0] tap_weight(input logic [HIST_W-1:0] i);
    logic [WEIGHT_W-1:0] w;
    case (i)
      4'd0:    w = 21'd0;
      4'd1:    w = 21'd322370;
      4'd2:    w = 21'd632351;
      4'd3:    w = 21'd918031;
      4'd4:    w = 21'd1168431;
      4'd5:    w = 21'd1373930;
      4'd6:    w = 21'd1526629;
      4'd7:    w = 21'd1620661;
      4'd8:    w = 21'd1652412;
      4'd9:    w = 21'd1620661;
      4'd10:   w = 21'd1526629;
      4'd11:   w = 21'd1373930;
      4'd12:   w = 21'd1168431;
      4'd13:   w = 21'd918031;
      4'd14:   w = 21'd632351;
      4'd15:   w = 21'd322370;
      default: w = 21'd0;
    endcase
    return w;
  endfunction

  // round half up to Q1.23 and saturate
  function automatic logic [SAMPLE_W-1:0] sat_scale(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] t;
    logic [SAMPLE_W-1:0] r;
    t = (prod + 52'sd4194304) >>> 23;
    if (t > 52'sd8388607) r = 24'h7FFFFF;
    else if (t < -52'sd8388608) r = 24'h800000;
    else r = t[SAMPLE_W-1:0];
    return r;
  endfunction

  // envelope: p + round(coef * (old - p) / 2^24), clamped to 24 bits
  function automatic logic [23:0] env_calc(input logic [23:0] p,
                                           input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] t;
    logic signed [28:0] e;
    logic [23:0] r;
    t = (prod + 52'sd8388608) >>> 24;
    e = $signed({5'b0, p}) + t[28:0];
    if (e < 29'sd0) r = 24'd0;
    else if (e > 29'sd16777215) r = 24'hFFFFFF;
    else r = e[23:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/lsl_if.sv
// ----------------------------------------------------------------------------
// lsl_if: stream channels of the limiter
// valid/ready channels for input frames and output frames
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface lsl_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lsl_pkg::SAMPLE_W-1:0] left_in;
  logic signed [lsl_pkg::SAMPLE_W-1:0] right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface lsl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lsl_pkg::SAMPLE_W-1:0] left_out;
  logic signed [lsl_pkg::SAMPLE_W-1:0] right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

### rtl/lsl_mul.sv
// ----------------------------------------------------------------------------
// lsl_mul: shared signed multiplier
// one registered signed product per enabled cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lsl_mul (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [lsl_pkg::MUL_W-1:0]    a,
  input  wire logic signed [lsl_pkg::MUL_W-1:0]    b,
  output logic signed [lsl_pkg::PROD_W-1:0]        prod
);
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end
endmodule
`default_nettype wire

### rtl/lsl_div.sv
// ----------------------------------------------------------------------------
// lsl_div: iterative restoring divider
// one quotient bit a cycle, quotient known to fit QUOT_W bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lsl_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lsl_pkg::div_req_t req,
  output lsl_pkg::div_rsp_t      rsp
);
  localparam int CNT_W = $clog2(lsl_pkg::QUOT_W + 1);
  localparam int LO_W  = lsl_pkg::NUM_W - lsl_pkg::QUOT_W;

  logic [lsl_pkg::PRED_W:0]    rem;
  logic [lsl_pkg::PRED_W-1:0]  den;
  logic [lsl_pkg::QUOT_W-1:0]  nlo;
  logic [lsl_pkg::QUOT_W-1:0]  quot;
  logic [CNT_W-1:0]            cnt;
  logic                        done;
  logic [lsl_pkg::PRED_W:0]    r2;

  assign r2 = {rem[lsl_pkg::PRED_W-1:0], nlo[lsl_pkg::QUOT_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(lsl_pkg::QUOT_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= {{(lsl_pkg::PRED_W + 1 - LO_W){1'b0}}, req.num[lsl_pkg::NUM_W-1 -: LO_W]};
      nlo <= req.num[lsl_pkg::QUOT_W-1:0];
      den <= req.den;
      quot <= '0;
    end else if (cnt != '0) begin
      nlo <= {nlo[lsl_pkg::QUOT_W-2:0], 1'b0};
      if (r2 >= {1'b0, den}) begin
        rem  <= r2 - {1'b0, den};
        quot <= {quot[lsl_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= r2;
        quot <= {quot[lsl_pkg::QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
endmodule
`default_nettype wire

### rtl/lookahead_stereo_peak_limiter.sv
// ----------------------------------------------------------------------------
// lookahead_stereo_peak_limiter: one frame in, one frame out, gain sequencer
// output loaded in push after the multiply, ramp and gain states; next frame
// taken only back in idle. Every fourth frame adds the 16-peak scan, envelopes
// and 16-tap sum, and the 24-step divide if the prediction tops the ceiling
// one shared multiplier and divider; a stalled output holds the push state
// reset is synchronous; history stores clear at once through valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lookahead_stereo_peak_limiter #(
  parameter int DELAY_DEPTH = lsl_pkg::DELAY_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lsl_pkg::GAIN_W-1:0]     cfg_data,
  lsl_in_if.sink                              in_ch,
  lsl_out_if.source                           out_ch
);
  localparam int DI_W = $clog2(DELAY_DEPTH);
  localparam int HW   = lsl_pkg::HIST_W;
  localparam int SW   = lsl_pkg::SAMPLE_W;
  localparam int MW   = lsl_pkg::MUL_W;
  localparam int CW   = 5;

  lsl_pkg::state_t state, state_next;

  logic [lsl_pkg::GAIN_W-1:0] ceiling_level;
  logic [DI_W-1:0]            di;
  logic                       filled;
  logic [HW-1:0]              hist;
  logic [CW-1:0]              cnt;
  logic [23:0]                peak;
  logic [23:0]                pmax;
  logic [23:0]                pe;
  logic [23:0]                se;
  logic [lsl_pkg::GAIN_W-1:0] gain_now;
  logic [lsl_pkg::GAIN_W-1:0] gain_before;
  logic [lsl_pkg::GAIN_W-1:0] gain_goal;
  logic [lsl_pkg::ACC_W-1:0]  acc;
  logic [SW-1:0]              res_l;
  logic [SW-1:0]              res_r;
  logic                       out_valid;
  logic [SW-1:0]              out_l;
  logic [SW-1:0]              out_r;

  logic [2*SW-1:0] dl_mem [DELAY_DEPTH];
  logic [2*SW-1:0] dl_rd;
  logic [23:0]     pk_mem [lsl_pkg::HISTORY_DEPTH];
  logic [lsl_pkg::HISTORY_DEPTH-1:0] pk_vld;
  logic [23:0]     pk_rd;
  logic [23:0]     sm_mem [lsl_pkg::HISTORY_DEPTH];
  logic [lsl_pkg::HISTORY_DEPTH-1:0] sm_vld;
  logic [23:0]     sm_rd;

  logic                          in_xfer;
  logic                          out_load;
  logic                          mul_en;
  logic signed [MW-1:0]          mul_a;
  logic signed [MW-1:0]          mul_b;
  logic signed [lsl_pkg::PROD_W-1:0] prod;
  lsl_pkg::div_req_t             div_req;
  lsl_pkg::div_rsp_t             div_rsp;

  logic [23:0]           abs_l, abs_r, in_peak;
  logic [DI_W-1:0]       di_next;
  logic                  update;
  logic signed [24:0]    diff;
  logic signed [24:0]    d1, d2;
  logic [2:0]            phase;
  logic [23:0]           e2;
  logic [23:0]           m12;
  logic [lsl_pkg::ACC_W-1:0] acc_rnd;
  logic [lsl_pkg::PRED_W-1:0] pred;
  logic [lsl_pkg::PROD_W-1:0] ramp_t;
  logic [HW-1:0]         sm_addr;
  logic [HW-1:0]         cnt_m1;
  logic [HW-1:0]         hist_inc;

  always_comb begin
    abs_l   = in_ch.left_in[SW-1]  ? 24'(-in_ch.left_in)  : in_ch.left_in;
    abs_r   = in_ch.right_in[SW-1] ? 24'(-in_ch.right_in) : in_ch.right_in;
    in_peak = (abs_l < abs_r) ? abs_r : abs_l;
  end

  assign di_next  = (di == DI_W'(DELAY_DEPTH - 1)) ? '0 : di + 1'b1;
  assign update   = (di_next[1:0] & 2'(lsl_pkg::RAMP_LENGTH - 1)) == 2'd0;
  assign phase    = {1'b0, di[1:0]} + 3'd1;
  assign diff     = $signed({1'b0, gain_goal}) - $signed({1'b0, gain_before});
  assign d1       = $signed({1'b0, pe}) - $signed({1'b0, pmax});
  assign d2       = $signed({1'b0, se}) - $signed({1'b0, pmax});
  assign e2       = lsl_pkg::env_calc(pmax, prod);
  assign m12      = (pmax < pe) ? pe : pmax;
  assign acc_rnd  = acc + lsl_pkg::ACC_W'(24'd8388608);
  assign pred     = acc_rnd[24 +: lsl_pkg::PRED_W];
  assign ramp_t   = lsl_pkg::PROD_W'((prod + 52'sd2) >>> 2);
  assign cnt_m1   = HW'(cnt - 1'b1);
  assign sm_addr  = hist + 1'b1 + cnt[HW-1:0];
  assign hist_inc = hist + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lsl_pkg::S_IDLE:  if (in_ch.valid) state_next = lsl_pkg::S_MUL_L;
      lsl_pkg::S_MUL_L: state_next = lsl_pkg::S_MUL_R;
      lsl_pkg::S_MUL_R: state_next = lsl_pkg::S_RAMP;
      lsl_pkg::S_RAMP:  state_next = lsl_pkg::S_GAIN;
      lsl_pkg::S_GAIN:  state_next = update ? lsl_pkg::S_SCAN : lsl_pkg::S_PUSH;
      lsl_pkg::S_SCAN:  if (cnt == CW'(16)) state_next = lsl_pkg::S_ENV1;
      lsl_pkg::S_ENV1:  state_next = lsl_pkg::S_ENV1W;
      lsl_pkg::S_ENV1W: state_next = lsl_pkg::S_ENV2W;
      lsl_pkg::S_ENV2W: state_next = lsl_pkg::S_SUM;
      lsl_pkg::S_SUM:   if (cnt == CW'(17)) state_next = lsl_pkg::S_PRED;
      lsl_pkg::S_PRED:  state_next = (ceiling_level < pred) ? lsl_pkg::S_DIV : lsl_pkg::S_FIN;
      lsl_pkg::S_DIV:   if (div_rsp.done) state_next = lsl_pkg::S_FIN;
      lsl_pkg::S_FIN:   state_next = lsl_pkg::S_PUSH;
      lsl_pkg::S_PUSH:  if (!out_valid || out_ch.ready) state_next = lsl_pkg::S_IDLE;
      default:          state_next = lsl_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs and shared multiplier operands
  always_comb begin
    in_ch.ready   = (state == lsl_pkg::S_IDLE);
    out_load      = (state == lsl_pkg::S_PUSH) && (!out_valid || out_ch.ready);
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = (state == lsl_pkg::S_PRED) && (ceiling_level < pred);
    div_req.num   = {ceiling_level, 23'd0} + lsl_pkg::NUM_W'(pred >> 1);
    div_req.den   = pred;
    case (state)
      lsl_pkg::S_MUL_L: begin
        mul_en = 1'b1;
        mul_a  = {{2{dl_rd[2*SW-1]}}, dl_rd[2*SW-1:SW]};
        mul_b  = {2'b0, gain_now};
      end
      lsl_pkg::S_MUL_R: begin
        mul_en = 1'b1;
        mul_a  = {{2{dl_rd[SW-1]}}, dl_rd[SW-1:0]};
        mul_b  = {2'b0, gain_now};
      end
      lsl_pkg::S_RAMP: begin
        mul_en = 1'b1;
        mul_a  = {23'd0, phase};
        mul_b  = {diff[24], diff};
      end
      lsl_pkg::S_ENV1: begin
        mul_en = 1'b1;
        mul_a  = {2'b0, (pe < pmax) ? lsl_pkg::COEF_RISE : lsl_pkg::COEF_FALL};
        mul_b  = {d1[24], d1};
      end
      lsl_pkg::S_ENV1W: begin
        mul_en = 1'b1;
        mul_a  = {2'b0, lsl_pkg::COEF_SECOND};
        mul_b  = {d2[24], d2};
      end
      lsl_pkg::S_SUM: begin
        mul_en = 1'b1;
        mul_a  = {2'b0, sm_rd};
        mul_b  = {5'd0, lsl_pkg::tap_weight(cnt_m1)};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign in_xfer = in_ch.valid && in_ch.ready;

  lsl_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  lsl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // delay line: read before write at the same index
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dl_rd <= filled ? dl_mem[di] : '0;
      dl_mem[di] <= {in_ch.left_in, in_ch.right_in};
    end
  end

  // peak store
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pk_rd <= pk_vld[hist] ? pk_mem[hist] : '0;
    end else if (state == lsl_pkg::S_SCAN && cnt < CW'(16)) begin
      pk_rd <= pk_vld[cnt[HW-1:0]] ? pk_mem[cnt[HW-1:0]] : '0;
    end
    if (state == lsl_pkg::S_MUL_L && pk_rd < peak) begin
      pk_mem[hist] <= peak;
    end
  end

  // smoothed store
  always_ff @(posedge clk) begin
    if (state == lsl_pkg::S_ENV2W) begin
      sm_mem[hist] <= (m12 < e2) ? e2 : m12;
    end
    if (state == lsl_pkg::S_SUM && cnt < CW'(16)) begin
      sm_rd <= sm_vld[sm_addr] ? sm_mem[sm_addr] : '0;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lsl_pkg::S_IDLE;
      ceiling_level <= lsl_pkg::UNITY_GAIN;
      di            <= '0;
      filled        <= 1'b0;
      hist          <= '0;
      cnt           <= '0;
      pk_vld        <= '0;
      sm_vld        <= '0;
      pe            <= '0;
      se            <= '0;
      gain_now      <= lsl_pkg::UNITY_GAIN;
      gain_before   <= lsl_pkg::UNITY_GAIN;
      gain_goal     <= lsl_pkg::UNITY_GAIN;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) ceiling_level <= cfg_data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        lsl_pkg::S_MUL_L: begin
          if (pk_rd < peak) pk_vld[hist] <= 1'b1;
        end
        lsl_pkg::S_GAIN: begin
          gain_now <= 24'($signed({2'b0, gain_before}) + $signed(ramp_t[25:0]));
          di       <= di_next;
          if (di_next == '0) filled <= 1'b1;
          cnt      <= '0;
        end
        lsl_pkg::S_SCAN: begin
          cnt <= cnt + 1'b1;
        end
        lsl_pkg::S_ENV1W: begin
          pe <= lsl_pkg::env_calc(pmax, prod);
        end
        lsl_pkg::S_ENV2W: begin
          se           <= e2;
          sm_vld[hist] <= 1'b1;
          cnt          <= '0;
        end
        lsl_pkg::S_SUM: begin
          cnt <= cnt + 1'b1;
        end
        lsl_pkg::S_PRED: begin
          gain_before <= gain_goal;
          if (!(ceiling_level < pred)) gain_goal <= lsl_pkg::UNITY_GAIN;
        end
        lsl_pkg::S_DIV: begin
          if (div_rsp.done) gain_goal <= div_rsp.quot;
        end
        lsl_pkg::S_FIN: begin
          hist             <= hist_inc;
          pk_vld[hist_inc] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) peak <= in_peak;
    if (state == lsl_pkg::S_MUL_R) res_l <= lsl_pkg::sat_scale(prod);
    if (state == lsl_pkg::S_RAMP)  res_r <= lsl_pkg::sat_scale(prod);
    if (state == lsl_pkg::S_GAIN)  pmax <= '0;
    if (state == lsl_pkg::S_SCAN && cnt != '0 && pmax < pk_rd) pmax <= pk_rd;
    if (state == lsl_pkg::S_ENV2W) acc <= '0;
    if (state == lsl_pkg::S_SUM && cnt >= CW'(2)) begin
      acc <= acc + lsl_pkg::ACC_W'(prod[45:0]);
    end
    if (out_load) begin
      out_l <= res_l;
      out_r <= res_r;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.left_out  = out_l;
  assign out_ch.right_out = out_r;

`ifndef SYNTHESIS
  a_gain_now_bound: assert property (@(posedge clk) disable iff (rst)
    gain_now <= lsl_pkg::UNITY_GAIN) else $error("gain_now above unity");
  a_gain_goal_bound: assert property (@(posedge clk) disable iff (rst)
    gain_goal <= lsl_pkg::UNITY_GAIN) else $error("gain_goal above unity");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == lsl_pkg::S_MUL_L) else $error("transfer did not start frame");
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == lsl_pkg::S_DIV) else $error("divider done out of place");
`endif
endmodule
`default_nettype wire
